>>> src/assert_macros.svh
// Assertion macros for the checker file of the link supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("supervisor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("supervisor check failed");

`endif

>>> src/sls_pkg.sv
// Types and constants of the SPI link supervisor.
`timescale 1ns / 1ps
`default_nettype none

package sls_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CMD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_CMD      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LIMIT  = 3'd4;

	// Item kinds.
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_TX_DONE = 2'd1;
	localparam logic [1:0] KIND_RX_DONE = 2'd2;
	localparam logic [1:0] KIND_ESTOP   = 2'd3;

	// Reported link states.
	localparam logic [1:0] LINK_IDLE      = 2'd0;
	localparam logic [1:0] LINK_RUNNING   = 2'd1;
	localparam logic [1:0] LINK_RESETTING = 2'd2;

	localparam logic [7:0] SAT_MAX = 8'hFF;

	localparam logic [7:0] RST_WRITE_CMD = 8'd1;
	localparam logic [7:0] RST_READ_CMD  = 8'd0;
	localparam logic [31:0] RST_COUNTER_START = 32'd0;
	localparam logic [7:0] RST_TIMEOUT_TICKS = 8'd5;
	localparam logic [7:0] RST_REJECT_LIMIT  = 8'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] command;
		logic       estop_level;
	} req_t;

	typedef struct packed {
		logic [1:0]  link_state;
		logic        accept_data;
		logic        clear_data;
		logic        notify;
		logic        link_error;
		logic [31:0] packet_count;
	} rsp_t;

endpackage

`default_nettype wire

>>> src/spi_link_supervisor.sv
// Top level of the SPI link supervisor: input register, engine, result register.
//
//   Channel  Direction  Handshake                 Payload
//   req      in         req_valid / req_stall     req (kind, command, estop_level)
//   rsp      out        rsp_valid / rsp_stall     rsp (state, strobes, packet_count)
//   cfg      in         cfg_wr_en                 cfg_index, cfg_data
//
// One item per cycle is accepted while the result register is not stalled; its result
// passes through the input register and the result register before it is presented.
// The engine updates all supervisor state in the cycle an item moves from the
// input register to the result register.
// Reset clears the pipeline and loads the register defaults at once.
// A stalled result holds the input register; the next item is stalled at the request port.
`timescale 1ns / 1ps
`default_nettype none

module spi_link_supervisor (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [sls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sls_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire sls_pkg::req_t                  req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output sls_pkg::rsp_t                       rsp
);
	import sls_pkg::*;

	logic  valid_s1;
	req_t  item_s1;
	logic  valid_s2;
	rsp_t  rsp_s2;
	rsp_t  result;
	logic  advance;
	logic  take;

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	sls_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (advance),
		.item      (item_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire

>>> src/sls_engine.sv
// Supervisor state, configuration registers and per-item update logic.
`timescale 1ns / 1ps
`default_nettype none

module sls_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [sls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sls_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          fire,
	input  wire sls_pkg::req_t                 item,
	output sls_pkg::rsp_t                      result
);
	import sls_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_RUNNING   = 2'd1,
		PH_RESETTING = 2'd2
	} phase_t;

	logic [7:0]  write_cmd_q;
	logic [7:0]  read_cmd_q;
	logic [7:0]  timeout_q;
	logic [7:0]  limit_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  silent_q, silent_d, silent_nx;
	logic        ready_q, ready_d;
	logic [7:0]  tally_q, tally_d;
	logic        error_q, error_d;
	logic        estop_q, estop_d;
	logic [31:0] tx_q, tx_d;

	logic        is_write, is_read;

	assign is_write = (item.command == write_cmd_q);
	assign is_read  = (item.command == read_cmd_q);

	always_comb begin
		phase_d   = phase_q;
		silent_d  = silent_q;
		silent_nx = silent_q;
		ready_d   = ready_q;
		tally_d   = tally_q;
		error_d   = error_q;
		estop_d   = estop_q;
		tx_d      = tx_q;
		result.accept_data = 1'b0;
		result.clear_data  = 1'b0;
		result.notify      = 1'b0;
		result.link_error  = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				result.link_error = error_q;
				error_d = 1'b0;
				case (phase_q)
					PH_IDLE: begin
						if (ready_q) begin
							phase_d = PH_RUNNING;
						end
					end
					PH_RUNNING: begin
						if (ready_q) begin
							silent_nx = 8'd0;
							ready_d   = 1'b0;
						end else if (silent_q != SAT_MAX) begin
							silent_nx = silent_q + 8'd1;
						end
						if (silent_nx > timeout_q) begin
							silent_d = 8'd0;
							phase_d  = PH_RESETTING;
						end else begin
							silent_d = silent_nx;
						end
					end
					default: begin
						result.clear_data = 1'b1;
						result.notify     = 1'b1;
						phase_d = PH_IDLE;
					end
				endcase
			end
			KIND_TX_DONE: begin
				tx_d = tx_q + 32'd1;
			end
			KIND_RX_DONE: begin
				if (is_write || is_read) begin
					if (is_write) begin
						result.accept_data = ~estop_q;
						result.notify      = 1'b1;
					end
					ready_d = 1'b1;
					tally_d = 8'd0;
				end else begin
					if (tally_q > limit_q) begin
						error_d = 1'b1;
					end
					if (tally_q != SAT_MAX) begin
						tally_d = tally_q + 8'd1;
					end
				end
			end
			default: begin
				estop_d = item.estop_level;
				result.notify = item.estop_level;
			end
		endcase
		result.link_state   = phase_d;
		result.packet_count = tx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_cmd_q <= RST_WRITE_CMD;
			read_cmd_q  <= RST_READ_CMD;
			timeout_q   <= RST_TIMEOUT_TICKS;
			limit_q     <= RST_REJECT_LIMIT;
			phase_q     <= PH_IDLE;
			silent_q    <= 8'd0;
			ready_q     <= 1'b0;
			tally_q     <= 8'd0;
			error_q     <= 1'b0;
			estop_q     <= 1'b0;
			tx_q        <= RST_COUNTER_START;
		end else begin
			if (fire) begin
				phase_q  <= phase_d;
				silent_q <= silent_d;
				ready_q  <= ready_d;
				tally_q  <= tally_d;
				error_q  <= error_d;
				estop_q  <= estop_d;
				tx_q     <= tx_d;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_WRITE_CMD:     write_cmd_q <= cfg_data[7:0];
					CFG_READ_CMD:      read_cmd_q  <= cfg_data[7:0];
					// The start value also presets the live counter.
					CFG_COUNTER_START: tx_q        <= cfg_data;
					CFG_TIMEOUT_TICKS: timeout_q   <= cfg_data[7:0];
					CFG_REJECT_LIMIT:  limit_q     <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> src/sls_checker.sv
// Port-level checks of the SPI link supervisor and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sls_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire sls_pkg::rsp_t rsp
);
	import sls_pkg::*;

	// A held result keeps its contents.
	`SLS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// The link state is always one of the three phases.
	`SLS_ASSERT_IMP(a_state_legal, clk, arst_n, rsp_valid,
		rsp.link_state == LINK_IDLE || rsp.link_state == LINK_RUNNING || rsp.link_state == LINK_RESETTING)

	// Data acceptance comes from a received packet, clearing from a tick: never both.
	`SLS_ASSERT_IMP(a_accept_clear, clk, arst_n, rsp_valid, !(rsp.accept_data && rsp.clear_data))

	// Exposed write data always comes with a notification.
	`SLS_ASSERT_IMP(a_accept_note, clk, arst_n, rsp_valid && rsp.accept_data, rsp.notify)

	// Clearing only happens on leaving the resetting phase.
	`SLS_ASSERT_IMP(a_clear_idle, clk, arst_n, rsp_valid && rsp.clear_data,
		rsp.link_state == LINK_IDLE && rsp.notify)

endmodule

bind spi_link_supervisor sls_checker u_sls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

>>> dv/tb_spi_link_supervisor.sv
// Self-checking testbench of the SPI link supervisor: directed and random items.
`timescale 1ns / 1ps

module tb_spi_link_supervisor;
	import sls_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;

	spi_link_supervisor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Register copies held by the predictor.
	logic [7:0]  cmd_write;
	logic [7:0]  cmd_read;
	logic [7:0]  silence_limit;
	logic [7:0]  reject_max;

	// Supervisor state held by the predictor.
	logic [1:0]  link_phase;
	logic [7:0]  quiet_ticks;
	logic        data_ready;
	logic [7:0]  reject_count;
	logic        error_pending;
	logic        estop_active;
	logic [31:0] tx_count;

	rsp_t pending_results[$];
	rsp_t oldest;
	int   errors;
	int   send_idle_pct;
	int   stall_pct;
	int   quiet_cycles;

	always #5 clk = ~clk;

	function automatic rsp_t link_outcome(input req_t it);
		rsp_t r;
		r = '0;
		case (it.kind)
		KIND_TICK: begin
			r.link_error = error_pending;
			error_pending = 1'b0;
			case (link_phase)
			LINK_IDLE: begin
				if (data_ready)
					link_phase = LINK_RUNNING;
			end
			LINK_RUNNING: begin
				if (data_ready) begin
					quiet_ticks = 8'd0;
					data_ready = 1'b0;
				end else if (quiet_ticks != SAT_MAX) begin
					quiet_ticks = quiet_ticks + 8'd1;
				end
				if (quiet_ticks > silence_limit) begin
					quiet_ticks = 8'd0;
					link_phase = LINK_RESETTING;
				end
			end
			default: begin
				r.clear_data = 1'b1;
				r.notify = 1'b1;
				link_phase = LINK_IDLE;
			end
			endcase
		end
		KIND_TX_DONE: begin
			tx_count = tx_count + 32'd1;
		end
		KIND_RX_DONE: begin
			if (it.command == cmd_write || it.command == cmd_read) begin
				// A code that names both commands acts as a write.
				if (it.command == cmd_write) begin
					r.accept_data = !estop_active;
					r.notify = 1'b1;
				end
				data_ready = 1'b1;
				reject_count = 8'd0;
			end else begin
				if (reject_count > reject_max)
					error_pending = 1'b1;
				if (reject_count != SAT_MAX)
					reject_count = reject_count + 8'd1;
			end
		end
		default: begin
			estop_active = it.estop_level;
			r.notify = it.estop_level;
		end
		endcase
		r.link_state = link_phase;
		r.packet_count = tx_count;
		return r;
	endfunction

	function automatic req_t make_item(input logic [1:0] kind, input logic [7:0] command,
			input logic level);
		req_t it;
		it.kind = kind;
		it.command = command;
		it.estop_level = level;
		return it;
	endfunction

	// Mostly valid command codes so that the link gets past idle; the rest is noise.
	function automatic req_t random_item();
		req_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			it.kind = KIND_TICK;
		else if (pick < 50)
			it.kind = KIND_TX_DONE;
		else if (pick < 90)
			it.kind = KIND_RX_DONE;
		else
			it.kind = KIND_ESTOP;
		pick = $urandom_range(99);
		if (pick < 40)
			it.command = cmd_write;
		else if (pick < 65)
			it.command = cmd_read;
		else
			it.command = 8'($urandom_range(255));
		it.estop_level = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic send_item(input req_t it);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(link_outcome(it));
	endtask

	task automatic send(input logic [1:0] kind, input logic [7:0] command, input logic level);
		send_item(make_item(kind, command, level));
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
		CFG_WRITE_CMD:     cmd_write = value[7:0];
		CFG_READ_CMD:      cmd_read = value[7:0];
		CFG_COUNTER_START: tx_count = value;
		CFG_TIMEOUT_TICKS: silence_limit = value[7:0];
		CFG_REJECT_LIMIT:  reject_max = value[7:0];
		default: ;
		endcase
	endtask

	task automatic write_all(input logic [7:0] wr_code, input logic [7:0] rd_code,
			input logic [31:0] preset, input logic [7:0] timeout, input logic [7:0] limit);
		write_reg(CFG_WRITE_CMD, {24'd0, wr_code});
		write_reg(CFG_READ_CMD, {24'd0, rd_code});
		write_reg(CFG_COUNTER_START, preset);
		write_reg(CFG_TIMEOUT_TICKS, {24'd0, timeout});
		write_reg(CFG_REJECT_LIMIT, {24'd0, limit});
	endtask

	// Every operation under the reset register values.
	task automatic test_defaults();
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_TX_DONE, 8'hFF, 1'b1);
		send(KIND_RX_DONE, RST_WRITE_CMD, 1'b0);
		send(KIND_RX_DONE, RST_READ_CMD, 1'b1);
		send(KIND_ESTOP, 8'h00, 1'b1);
		send(KIND_RX_DONE, RST_WRITE_CMD, 1'b0);
		send(KIND_ESTOP, 8'hFF, 1'b0);
		send(KIND_RX_DONE, 8'hFF, 1'b0);
		send(KIND_TICK, 8'hAA, 1'b1);
		send(KIND_TICK, 8'h55, 1'b0);
		drain();
	endtask

	// Running to resetting to idle with the shortest timeout.
	task automatic test_link_timeout();
		write_reg(CFG_TIMEOUT_TICKS, 32'd0);
		send(KIND_RX_DONE, cmd_read, 1'b0);
		repeat (5)
			send(KIND_TICK, 8'h00, 1'b0);
		drain();
	endtask

	// With a limit of zero the second reject raises the error; one tick reports it.
	task automatic test_reject_error();
		write_reg(CFG_REJECT_LIMIT, 32'd0);
		repeat (3)
			send(KIND_RX_DONE, 8'h80, 1'b0);
		send(KIND_ESTOP, 8'h00, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		drain();
	endtask

	task automatic test_counter_preset();
		write_reg(CFG_COUNTER_START, 32'hFFFF_FFFE);
		repeat (3)
			send(KIND_TX_DONE, 8'h00, 1'b0);
		drain();
		write_reg(CFG_COUNTER_START, 32'd0);
		send(KIND_TX_DONE, 8'h00, 1'b0);
		drain();
	endtask

	task automatic test_shared_code();
		write_reg(CFG_WRITE_CMD, 32'h5A);
		write_reg(CFG_READ_CMD, 32'h5A);
		send(KIND_RX_DONE, 8'h5A, 1'b0);
		send(KIND_RX_DONE, 8'h00, 1'b0);
		drain();
	endtask

	// Reject tally and silence counter both pinned at their maximum.
	task automatic test_saturation();
		write_reg(CFG_REJECT_LIMIT, 32'd255);
		repeat (256)
			send(KIND_RX_DONE, 8'h00, 1'b1);
		send(KIND_TICK, 8'h00, 1'b0);
		drain();
		write_reg(CFG_REJECT_LIMIT, 32'd254);
		send(KIND_RX_DONE, 8'h00, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		drain();
		write_reg(CFG_TIMEOUT_TICKS, 32'd255);
		// This sequence leaves the link running from any phase.
		send(KIND_RX_DONE, cmd_read, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_RX_DONE, cmd_read, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		repeat (256)
			send(KIND_TICK, 8'h00, 1'b0);
		drain();
		write_reg(CFG_TIMEOUT_TICKS, 32'd254);
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		drain();
	endtask

	task automatic test_random(input int idle, input int stall, input int count);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			send_item(random_item());
		drain();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		errors = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		cmd_write = RST_WRITE_CMD;
		cmd_read = RST_READ_CMD;
		silence_limit = RST_TIMEOUT_TICKS;
		reject_max = RST_REJECT_LIMIT;
		link_phase = LINK_IDLE;
		quiet_ticks = 8'd0;
		data_ready = 1'b0;
		reject_count = 8'd0;
		error_pending = 1'b0;
		estop_active = 1'b0;
		tx_count = RST_COUNTER_START;
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_link_timeout();
		test_reject_error();
		test_counter_preset();
		test_shared_code();
		test_saturation();

		write_all(8'hFF, 8'h00, 32'hFFFF_FFFF, 8'd0, 8'd0);
		test_random(0, 0, 40);
		write_all(8'($urandom_range(255)), 8'($urandom_range(255)), $urandom,
			8'($urandom_range(4)), 8'($urandom_range(3)));
		test_random(52, 0, 40);
		write_all(8'h00, 8'hFF, 32'd0, 8'd2, 8'd255);
		test_random(0, 52, 40);
		write_all(8'($urandom_range(255)), 8'($urandom_range(255)), $urandom,
			8'($urandom_range(6)), 8'($urandom_range(5)));
		test_random(22, 22, 40);

		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("** spi_link_supervisor: PASSED **");
		else
			$display("** spi_link_supervisor: FAILED **");
		$finish;
	end

	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < stall_pct);

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("link_state", 32'(oldest.link_state), 32'(rsp.link_state));
				check_field("accept_data", 32'(oldest.accept_data), 32'(rsp.accept_data));
				check_field("clear_data", 32'(oldest.clear_data), 32'(rsp.clear_data));
				check_field("notify", 32'(oldest.notify), 32'(rsp.notify));
				check_field("link_error", 32'(oldest.link_error), 32'(rsp.link_error));
				check_field("packet_count", oldest.packet_count, rsp.packet_count);
			end
		end
	end

	// Ends a hung run: counts cycles in which no item, result or register write moves.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** spi_link_supervisor: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial quiet_cycles = 0;

endmodule

>>> files.f
+incdir+src
src/sls_pkg.sv
src/sls_engine.sv
src/spi_link_supervisor.sv
src/sls_checker.sv
dv/tb_spi_link_supervisor.sv
